[rtl/core/wes_pkg.sv]
// Shared types and constants of the wave equation stencil step core.
// Depends on nothing; every other file of the core but wes_ram uses it by scoped names.
package wes_pkg;

    localparam int DATA_W      = 32;
    localparam int COEFF_W     = 20;
    localparam int GRID_W      = 10;
    localparam int IDX_W       = 9;
    localparam int LAP_W       = 40;
    localparam int GRID_MIN    = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int TDATA_IN_W  = 64;
    localparam int TDATA_OUT_W = 56;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID  = 2'd2;

    localparam logic               ORDER_RST = 1'b1;
    localparam logic [COEFF_W-1:0] COEFF_RST = 20'd21845;
    localparam logic [GRID_W-1:0]  GRID_RST  = 10'd300;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } wes_pos_t;

    // Decode of one accepted cell, from the scan counters to the line stage
    typedef struct packed {
        logic     emit;
        logic     reach2;
        logic [1:0] slot_c;
        logic [1:0] slot_r;
        logic     par_c;
        logic     par_r;
        wes_pos_t pos;
    } wes_scan_t;

    // Laplacian stage result handed to the update stages
    typedef struct packed {
        logic                     valid;
        logic signed [LAP_W-1:0]  lap;
        logic signed [DATA_W-1:0] pc;
        logic signed [DATA_W-1:0] pp;
        wes_pos_t                 pos;
    } wes_stencil_t;

endpackage

[rtl/core/wave_equation_stencil_step_core.sv]
// A result is registered in turn in the window, operand, product and output stages (line read,
// Laplacian, multiply, round and saturate) before it shows on m_tvalid. Throughput: one cell
// per cycle unless m_tready stalls, set by one write and two reads per line RAM each cycle.
// Reset (aresetn, synchronous, active low) clears counters, stage valids and config registers;
// line memories are not cleared and need no clearing pass.
module wave_equation_stencil_step_core #(
    parameter int MAX_GRID  = 512,
    parameter int FRAC_BITS = 20
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [wes_pkg::CFG_IDX_W-1:0]        cfg_wr_idx,
    input  logic [wes_pkg::COEFF_W-1:0]          cfg_wr_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [wes_pkg::TDATA_IN_W-1:0]       s_tdata,   // p_now, p_prev
    input  logic                                 s_tuser,   // first_cell
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [wes_pkg::TDATA_OUT_W-1:0]      m_tdata    // p_next, out_row, out_col, zero pad
);

    logic                               order_reg;
    logic [wes_pkg::COEFF_W-1:0]        coeff_reg;
    logic [wes_pkg::GRID_W-1:0]         grid_reg;
    logic                               accept, free_1, free_2;
    wes_pkg::wes_scan_t                 scan;
    wes_pkg::wes_stencil_t              stencil;
    wes_pkg::wes_pos_t                  pos_out;
    logic [$clog2(MAX_GRID)-1:0]        col_addr, col_ahead;
    logic [wes_pkg::DATA_W-1:0]         p_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= wes_pkg::ORDER_RST;
            coeff_reg <= wes_pkg::COEFF_RST;
            grid_reg  <= wes_pkg::GRID_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_idx)
                wes_pkg::REG_ORDER: order_reg <= cfg_wr_data[0];
                wes_pkg::REG_COEFF: coeff_reg <= cfg_wr_data;
                wes_pkg::REG_GRID:  grid_reg  <= cfg_wr_data[wes_pkg::GRID_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = free_1;
    assign accept   = s_tvalid && s_tready;

    wes_scan #(
        .MAX_GRID (MAX_GRID)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .first_cell (s_tuser),
        .order_sel  (order_reg),
        .grid_size  (grid_reg),
        .scan       (scan),
        .col_addr   (col_addr),
        .col_ahead  (col_ahead)
    );

    wes_lines #(
        .MAX_GRID (MAX_GRID)
    ) u_lines (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .p_now     (s_tdata[wes_pkg::DATA_W-1:0]),
        .p_prev    (s_tdata[2*wes_pkg::DATA_W-1:wes_pkg::DATA_W]),
        .scan      (scan),
        .col_addr  (col_addr),
        .col_ahead (col_ahead),
        .free_2    (free_2),
        .free_1    (free_1),
        .stencil   (stencil)
    );

    wes_update #(
        .FRAC_BITS (FRAC_BITS)
    ) u_update (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stencil  (stencil),
        .coeff    (coeff_reg),
        .free_2   (free_2),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .p_next   (p_next),
        .pos      (pos_out)
    );

    assign m_tdata = {{(wes_pkg::TDATA_OUT_W - wes_pkg::DATA_W - 2*wes_pkg::IDX_W){1'b0}},
                      pos_out.col, pos_out.row, p_next};

    // With the output register empty nothing may hold the input back
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output stage is empty");

endmodule

[rtl/core/wes_ram.sv]
// Generic RAM: one write port, two read ports, registered read data.
// Depends on nothing.
module wes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Reads return the contents from before a write to the same address
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

[rtl/core/wes_scan.sv]
// Raster position counters and per-cell decode: window reach, line slots, emit test.
// Depends on wes_pkg.
module wes_scan #(
    parameter int MAX_GRID = 512
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic                              first_cell,
    input  logic                              order_sel,
    input  logic [wes_pkg::GRID_W-1:0]        grid_size,
    output wes_pkg::wes_scan_t                scan,
    output logic [$clog2(MAX_GRID)-1:0]       col_addr,
    output logic [$clog2(MAX_GRID)-1:0]       col_ahead
);

    localparam int AW = $clog2(MAX_GRID);
    localparam int CW = (AW + 1 > wes_pkg::GRID_W) ? AW + 1 : wes_pkg::GRID_W + 1;
    localparam logic [CW-1:0] GMAX = CW'(MAX_GRID);
    localparam logic [CW-1:0] GMIN = CW'(wes_pkg::GRID_MIN);

    logic [AW-1:0] row_reg, row_next, col_reg, col_next;
    logic [AW-1:0] row_cur, col_cur, reach_a, row_c;
    logic [CW-1:0] g_ext, g_eff, g_last, row_w, col_w, reach_w;

    always_comb begin
        g_ext = CW'(grid_size);
        if (g_ext < GMIN) begin
            g_eff = GMIN;
        end else if (g_ext > GMAX) begin
            g_eff = GMAX;
        end else begin
            g_eff = g_ext;
        end
        g_last  = g_eff - CW'(1);

        row_cur = first_cell ? '0 : row_reg;
        col_cur = first_cell ? '0 : col_reg;
        row_w   = CW'(row_cur);
        col_w   = CW'(col_cur);
        reach_w = order_sel ? CW'(2) : CW'(1);
        reach_a = order_sel ? AW'(2) : AW'(1);
        row_c   = row_cur - reach_a;

        scan.emit   = (row_w >= (reach_w << 1)) && (row_w <= g_last)
                      && (col_w >= reach_w) && (col_w <= g_last - reach_w);
        scan.reach2 = order_sel;
        scan.slot_c = row_c[1:0];
        scan.slot_r = row_cur[1:0];
        scan.par_c  = row_c[0];
        scan.par_r  = row_cur[0];
        scan.pos.row = wes_pkg::IDX_W'(row_c);
        scan.pos.col = wes_pkg::IDX_W'(col_cur);

        col_addr  = col_cur;
        col_ahead = col_cur + AW'(2);

        // Wrap the column at the row end, the row at the grid end
        if (col_w >= g_last) begin
            col_next = '0;
            row_next = (row_w >= g_last) ? '0 : row_cur + AW'(1);
        end else begin
            col_next = col_cur + AW'(1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // An emitting cell never sits at the row end, so the column cannot wrap after it
    a_emit_no_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && scan.emit) |=> (col_reg != '0))
        else $error("column wrapped after an emitting cell");

endmodule

[rtl/core/wes_lines.sv]
// Line memories of current and previous field values, window history and Laplacian.
// Depends on wes_pkg and wes_ram.
module wes_lines #(
    parameter int MAX_GRID = 512
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  logic [wes_pkg::DATA_W-1:0]          p_now,
    input  logic [wes_pkg::DATA_W-1:0]          p_prev,
    input  wes_pkg::wes_scan_t                  scan,
    input  logic [$clog2(MAX_GRID)-1:0]         col_addr,
    input  logic [$clog2(MAX_GRID)-1:0]         col_ahead,
    input  logic                                free_2,
    output logic                                free_1,
    output wes_pkg::wes_stencil_t               stencil
);

    localparam int AW = $clog2(MAX_GRID);

    function automatic logic signed [wes_pkg::LAP_W-1:0] sx(
        input logic [wes_pkg::DATA_W-1:0] v
    );
        sx = wes_pkg::LAP_W'($signed(v));
    endfunction

    logic [wes_pkg::DATA_W-1:0] rda [4];
    logic [wes_pkg::DATA_W-1:0] rdb [4];
    logic [wes_pkg::DATA_W-1:0] hist_a1 [4];
    logic [wes_pkg::DATA_W-1:0] hist_a2 [4];
    logic [wes_pkg::DATA_W-1:0] hist_b1 [4];
    logic [wes_pkg::DATA_W-1:0] pp_rd;

    logic                       v1_reg;
    logic [wes_pkg::DATA_W-1:0] now_reg;
    logic                       reach2_reg;
    logic [1:0]                 sc_reg;
    wes_pkg::wes_pos_t          pos_reg;

    logic [1:0] sc_n1, sc_n2, sc_s1;
    logic signed [wes_pkg::LAP_W-1:0] vc, vn1, vn2, vs1, vs2, vw1, vw2, ve1, ve2;
    logic signed [wes_pkg::LAP_W-1:0] near_sum, far_sum, lap;

    // One p_now line per row modulo four, indexed by column
    for (genvar k = 0; k < 4; k++) begin : g_line
        wes_ram #(
            .WIDTH (wes_pkg::DATA_W),
            .DEPTH (MAX_GRID)
        ) u_line (
            .aclk      (aclk),
            .wr_en     (accept && (scan.slot_r == 2'(k))),
            .wr_addr   (col_addr),
            .wr_data   (p_now),
            .rd_en     (accept),
            .rd_addr_a (col_addr),
            .rd_data_a (rda[k]),
            .rd_addr_b (col_ahead),
            .rd_data_b (rdb[k])
        );
    end

    // p_prev lines, row modulo two in the top address bit
    wes_ram #(
        .WIDTH (wes_pkg::DATA_W),
        .DEPTH (2 * (1 << AW))
    ) u_prev (
        .aclk      (aclk),
        .wr_en     (accept),
        .wr_addr   ({scan.par_r, col_addr}),
        .wr_data   (p_prev),
        .rd_en     (accept),
        .rd_addr_a ({scan.par_c, col_addr}),
        .rd_data_a (pp_rd),
        .rd_addr_b ({scan.par_c, col_addr}),
        .rd_data_b ()
    );

    assign free_1 = !v1_reg || free_2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (free_1) begin
            v1_reg <= accept && scan.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            now_reg    <= p_now;
            reach2_reg <= scan.reach2;
            sc_reg     <= scan.slot_c;
            pos_reg    <= scan.pos;
            // Earlier cells of the same row supply the west and first east taps
            for (int k = 0; k < 4; k++) begin
                hist_a2[k] <= hist_a1[k];
                hist_a1[k] <= rda[k];
                hist_b1[k] <= rdb[k];
            end
        end
    end

    always_comb begin
        sc_n1 = sc_reg - 2'd1;
        sc_n2 = sc_reg - 2'd2;
        sc_s1 = sc_reg + 2'd1;

        vc  = sx(rda[sc_reg]);
        vn1 = sx(rda[sc_n1]);
        vn2 = sx(rda[sc_n2]);
        vs1 = reach2_reg ? sx(rda[sc_s1]) : sx(now_reg);
        vs2 = sx(now_reg);
        vw1 = sx(hist_a1[sc_reg]);
        vw2 = sx(hist_a2[sc_reg]);
        ve1 = sx(hist_b1[sc_reg]);
        ve2 = sx(rdb[sc_reg]);

        near_sum = vn1 + vs1 + vw1 + ve1;
        far_sum  = vn2 + vs2 + vw2 + ve2;
        if (reach2_reg) begin
            lap = (near_sum <<< 4) - far_sum - (vc <<< 6) + (vc <<< 2);
        end else begin
            lap = near_sum - (vc <<< 2);
        end

        stencil.valid = v1_reg;
        stencil.lap   = lap;
        stencil.pc    = $signed(rda[sc_reg]);
        stencil.pp    = $signed(pp_rd);
        stencil.pos   = pos_reg;
    end

    a_v1_from_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v1_reg) |-> $past(accept))
        else $error("window stage filled without an accepted item");

endmodule

[rtl/core/wes_update.sv]
// Leapfrog update: coefficient multiply, rounding, 2*now - prev, saturation, output register.
// Depends on wes_pkg.
module wes_update #(
    parameter int FRAC_BITS = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wes_pkg::wes_stencil_t         stencil,
    input  logic [wes_pkg::COEFF_W-1:0]   coeff,
    output logic                          free_2,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wes_pkg::DATA_W-1:0]    p_next,
    output wes_pkg::wes_pos_t             pos
);

    localparam int PROD_W = wes_pkg::LAP_W + wes_pkg::COEFF_W + 1;
    localparam int BASE_W = wes_pkg::DATA_W + 2;
    localparam int SUM_W  = PROD_W + 1;
    localparam int HI_W   = SUM_W - wes_pkg::DATA_W + 1;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [wes_pkg::DATA_W-1:0] SAT_HI = {1'b0, {(wes_pkg::DATA_W-1){1'b1}}};
    localparam logic [wes_pkg::DATA_W-1:0] SAT_LO = {1'b1, {(wes_pkg::DATA_W-1){1'b0}}};

    logic                                v2_reg, v3_reg, m_valid_reg;
    logic                                free_3, free_m;
    logic signed [wes_pkg::LAP_W-1:0]    lap2_reg;
    logic signed [wes_pkg::DATA_W-1:0]   pc2_reg, pp2_reg;
    wes_pkg::wes_pos_t                   pos2_reg, pos3_reg, pos_m_reg;
    logic signed [PROD_W-1:0]            prod_reg, prod_next;
    logic signed [BASE_W-1:0]            base_reg, base_next;
    logic signed [wes_pkg::COEFF_W:0]    coeff_s;
    logic signed [PROD_W-1:0]            rnd;
    logic signed [SUM_W-1:0]             sum_v;
    logic [HI_W-1:0]                     hi;
    logic [wes_pkg::DATA_W-1:0]          p_next_reg, p_next_next;

    assign free_m = !m_valid_reg || m_tready;
    assign free_3 = !v3_reg || free_m;
    assign free_2 = !v2_reg || free_3;

    always_comb begin
        coeff_s   = $signed({1'b0, coeff});
        prod_next = lap2_reg * coeff_s;
        base_next = (BASE_W'(pc2_reg) <<< 1) - BASE_W'(pp2_reg);

        // Round half up, then add the leapfrog terms
        rnd   = (prod_reg + $signed(HALF)) >>> FRAC_BITS;
        sum_v = SUM_W'(rnd) + SUM_W'(base_reg);
        hi    = sum_v[SUM_W-1:wes_pkg::DATA_W-1];
        if (&hi || ~|hi) begin
            p_next_next = sum_v[wes_pkg::DATA_W-1:0];
        end else if (sum_v[SUM_W-1]) begin
            p_next_next = SAT_LO;
        end else begin
            p_next_next = SAT_HI;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (free_2) begin
                v2_reg <= stencil.valid;
            end
            if (free_3) begin
                v3_reg <= v2_reg;
            end
            if (free_m) begin
                m_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (free_2 && stencil.valid) begin
            lap2_reg <= stencil.lap;
            pc2_reg  <= stencil.pc;
            pp2_reg  <= stencil.pp;
            pos2_reg <= stencil.pos;
        end
        if (free_3 && v2_reg) begin
            prod_reg <= prod_next;
            base_reg <= base_next;
            pos3_reg <= pos2_reg;
        end
        if (free_m && v3_reg) begin
            p_next_reg <= p_next_next;
            pos_m_reg  <= pos3_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign p_next   = p_next_reg;
    assign pos      = pos_m_reg;

    a_s3_moves_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && free_m) |=> m_valid_reg)
        else $error("product stage item lost on its way to the output");

endmodule
